// ===== rtl/core/wch_pkg.sv =====
`timescale 1ns / 1ps

package wch_pkg;

  localparam int BINS_A = 16;
  localparam int BINS_B = 16;
  localparam int BINS_C = 16;

  localparam int NUM_CH = 3;
  localparam int DATA_W = 16;
  localparam int ADDR_W = 12;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int BIN_W  = 32;
  localparam int TOT_W  = 40;

  localparam int BINS_AB  = (BINS_A > BINS_B) ? BINS_A : BINS_B;
  localparam int BINS_MAX = (BINS_AB > BINS_C) ? BINS_AB : BINS_C;

  // quotient bits per channel, one restoring step each
  localparam int DIV_STEPS = (BINS_MAX > 1) ? $clog2(BINS_MAX) : 1;
  localparam int IDX_W     = DIV_STEPS;
  localparam int NUM_W     = DATA_W + $clog2(BINS_MAX + 1);
  localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHAN_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHAN_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHAN_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHAN_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHAN_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHAN_C = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QUANT,
    S_DIV,
    S_ADDR,
    S_FIN
  } state_t;

  function automatic int chan_bins(input int ch);
    int b;
    case (ch)
      0:       b = BINS_A;
      1:       b = BINS_B;
      default: b = BINS_C;
    endcase
    return b;
  endfunction

  function automatic logic [BIN_W-1:0] sat_bin(input logic [BIN_W+1:0] x);
    logic [BIN_W-1:0] r;
    if (x[BIN_W+1] == x[BIN_W] && x[BIN_W] == x[BIN_W-1]) begin
      r = x[BIN_W-1:0];
    end else if (x[BIN_W+1]) begin
      r = {1'b1, {(BIN_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(BIN_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W+1:0] x);
    logic [TOT_W-1:0] r;
    if (x[TOT_W+1] == x[TOT_W] && x[TOT_W] == x[TOT_W-1]) begin
      r = x[TOT_W-1:0];
    end else if (x[TOT_W+1]) begin
      r = {1'b1, {(TOT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(TOT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/wch_sample_if.sv =====
`timescale 1ns / 1ps

interface wch_sample_if;
  import wch_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic              prebinned;
  logic [DATA_W-1:0] chan_a;
  logic [DATA_W-1:0] chan_b;
  logic [DATA_W-1:0] chan_c;
  logic [DATA_W-1:0] weight;

  modport source (
    output valid, func, prebinned, chan_a, chan_b, chan_c, weight,
    input  ready
  );

  modport sink (
    input  valid, func, prebinned, chan_a, chan_b, chan_c, weight,
    output ready
  );
endinterface

// ===== rtl/core/wch_result_if.sv =====
`timescale 1ns / 1ps

interface wch_result_if;
  import wch_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        bin_index;
  logic signed [BIN_W-1:0]  bin_value;
  logic signed [TOT_W-1:0]  weight_total;
  logic                     dropped;

  modport source (
    output valid, bin_index, bin_value, weight_total, dropped,
    input  ready
  );

  modport sink (
    input  valid, bin_index, bin_value, weight_total, dropped,
    output ready
  );
endinterface

// ===== rtl/core/wch_ram.sv =====
`timescale 1ns / 1ps

module wch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/weighted_color_histogram.sv =====
`timescale 1ns / 1ps

// Weighted 3-D color histogram. Each item quantizes three channels against
// the programmed [min, max] ranges (or takes ready-made bin indices), then
// adds or subtracts its Q8.8 weight to one bin of a 4096-entry memory with
// saturation, and returns the bin's new content plus the saturated running
// weight total; an item out of range is dropped and flagged. Items are taken
// one at a time, passing in order through acceptance, range checks and
// scaling, DIV_STEPS restoring divider steps (one quotient bit per cycle per
// channel), the address and memory read, and the update, which waits while a
// held result is not yet taken; no new item is taken until the last is done.
// The result register lets the next item start while a result waits. After
// reset a clearing pass writes zero to all 4096 bins, one per cycle; no item
// is taken during that pass, but configuration writes are.
module weighted_color_histogram (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wch_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [wch_pkg::DATA_W-1:0]       cfg_wdata,
  wch_sample_if.sink                       sample,
  wch_result_if.source                     result
);
  import wch_pkg::*;

  state_t state, state_next;

  logic [DATA_W-1:0] cfg_min [NUM_CH];
  logic [DATA_W-1:0] cfg_max [NUM_CH];

  // latched item
  logic              func_q;
  logic              pre_q;
  logic [DATA_W-1:0] chan_q [NUM_CH];
  logic [DATA_W-1:0] weight_q;

  // quantizer lanes
  logic              ok_ch   [NUM_CH];
  logic              top_ch  [NUM_CH];
  logic [NUM_W-1:0]  num_ch  [NUM_CH];
  logic [NUM_W-1:0]  dsr_ch  [NUM_CH];
  logic              ok_q;
  logic              top_q   [NUM_CH];
  logic [NUM_W-1:0]  rem     [NUM_CH];
  logic [NUM_W-1:0]  dsr     [NUM_CH];
  logic [IDX_W-1:0]  quo     [NUM_CH];
  logic              rem_ge  [NUM_CH];
  logic [IDX_W-1:0]  idx_ch  [NUM_CH];
  logic [CNT_W-1:0]  cnt;

  logic [ADDR_W-1:0] row;
  logic [ADDR_W-1:0] addr_next;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] clr_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BIN_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BIN_W-1:0]  ram_rdata;

  logic signed [DATA_W+1:0] w_s;
  logic [BIN_W+1:0]  bin_sum;
  logic [TOT_W+1:0]  tot_sum;
  logic [BIN_W-1:0]  bin_new;
  logic [TOT_W-1:0]  weight_sum;
  logic              out_load;

  logic              out_valid;
  logic [ADDR_W-1:0] out_index;
  logic [BIN_W-1:0]  out_value;
  logic [TOT_W-1:0]  out_total;
  logic              out_dropped;

  wch_ram #(
    .WIDTH (BIN_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        cfg_min[c] <= '0;
        cfg_max[c] <= '1;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_CHAN_A: cfg_min[0] <= cfg_wdata;
        REG_MAX_CHAN_A: cfg_max[0] <= cfg_wdata;
        REG_MIN_CHAN_B: cfg_min[1] <= cfg_wdata;
        REG_MAX_CHAN_B: cfg_max[1] <= cfg_wdata;
        REG_MIN_CHAN_C: cfg_min[2] <= cfg_wdata;
        REG_MAX_CHAN_C: cfg_max[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // range checks, scaled offset and shifted span per channel
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (pre_q) begin
        ok_ch[c] = chan_q[c] < DATA_W'(chan_bins(c));
      end else begin
        ok_ch[c] = (cfg_max[c] > cfg_min[c]) && (chan_q[c] >= cfg_min[c])
                   && (chan_q[c] <= cfg_max[c]);
      end
      top_ch[c] = chan_q[c] == cfg_max[c];
      num_ch[c] = NUM_W'(chan_q[c] - cfg_min[c]) * NUM_W'(chan_bins(c));
      dsr_ch[c] = NUM_W'(cfg_max[c] - cfg_min[c]) << (DIV_STEPS - 1);
      rem_ge[c] = rem[c] >= dsr[c];
      if (pre_q) begin
        idx_ch[c] = chan_q[c][IDX_W-1:0];
      end else if (top_q[c]) begin
        idx_ch[c] = IDX_W'(chan_bins(c) - 1);
      end else begin
        idx_ch[c] = quo[c];
      end
    end
    row       = ADDR_W'(idx_ch[2]) * ADDR_W'(BINS_B) + ADDR_W'(idx_ch[1]);
    addr_next = row * ADDR_W'(BINS_A) + ADDR_W'(idx_ch[0]);
  end

  // bin and total update
  always_comb begin
    w_s = func_q ? -$signed({2'b00, weight_q}) : $signed({2'b00, weight_q});
    bin_sum = {{2{ram_rdata[BIN_W-1]}}, ram_rdata} + (BIN_W + 2)'(w_s);
    tot_sum = {{2{weight_sum[TOT_W-1]}}, weight_sum} + (TOT_W + 2)'(w_s);
    bin_new = sat_bin(bin_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = addr_q;
    ram_wdata    = bin_new;
    ram_raddr    = addr_q;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = S_QUANT;
        end
      end
      S_QUANT: state_next = S_DIV;
      S_DIV: begin
        if (cnt == '0) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        ram_raddr  = addr_next;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          ram_we     = ok_q;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      func_q    <= sample.func;
      pre_q     <= sample.prebinned;
      chan_q[0] <= sample.chan_a;
      chan_q[1] <= sample.chan_b;
      chan_q[2] <= sample.chan_c;
      weight_q  <= sample.weight;
    end
    case (state)
      S_QUANT: begin
        ok_q <= ok_ch[0] && ok_ch[1] && ok_ch[2];
        cnt  <= CNT_W'(DIV_STEPS - 1);
        for (int c = 0; c < NUM_CH; c++) begin
          top_q[c] <= top_ch[c];
          rem[c]   <= num_ch[c];
          dsr[c]   <= dsr_ch[c];
          quo[c]   <= '0;
        end
      end
      S_DIV: begin
        cnt <= cnt - 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
          if (rem_ge[c]) begin
            rem[c] <= rem[c] - dsr[c];
          end
          quo[c] <= (quo[c] << 1) | IDX_W'(rem_ge[c]);
          dsr[c] <= dsr[c] >> 1;
        end
      end
      S_ADDR: addr_q <= addr_next;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_sum <= '0;
    end else if (out_load && ok_q) begin
      weight_sum <= sat_tot(tot_sum);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dropped <= !ok_q;
      if (ok_q) begin
        out_index <= addr_q;
        out_value <= bin_new;
        out_total <= sat_tot(tot_sum);
      end else begin
        out_index <= '0;
        out_value <= '0;
        out_total <= weight_sum;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.bin_index    = out_index;
  assign result.bin_value    = out_value;
  assign result.weight_total = out_total;
  assign result.dropped      = out_dropped;

  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("item accepted while another is in flight");

  // a dropped item leaves no bin in the result
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.dropped |-> result.bin_index == '0 && result.bin_value == '0)
    else $error("dropped result carries a bin");

  // write-back goes to the entry that was read
  a_rmw_addr: assert property (@(posedge clk) disable iff (rst)
    ram_we && state != S_CLEAR |-> ram_waddr == ram_raddr && state == S_FIN)
    else $error("bin write does not match bin read");

endmodule

// ===== dv/weighted_color_histogram_tb.sv =====
`timescale 1ns / 1ps

module weighted_color_histogram_tb;
  import wch_pkg::*;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  localparam int IDLE_PCT          = 27;
  localparam int STALL_LIMIT       = 12000;
  localparam int ITEMS_PER_SETTING = 190;
  localparam int NUM_SETTINGS      = 7;
  localparam int HOLD_CYCLES       = 300;
  localparam int QUIET_RUN         = 30;
  localparam int DRAIN_CYCLES      = 24;
  localparam int REPORT_MAX        = 10;

  localparam longint BIN_HI = 64'sd2147483647;
  localparam longint BIN_LO = -64'sd2147483648;
  localparam longint TOT_HI = 64'sd549755813887;
  localparam longint TOT_LO = -64'sd549755813888;

  typedef struct packed {
    logic              func;
    logic              prebinned;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] w;
  } pixel_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       idx;
    logic signed [BIN_W-1:0] val;
    logic signed [TOT_W-1:0] tot;
    logic                    dropped;
  } update_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    pixel_t                px;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [DATA_W-1:0]     reg_val;
    bit                    typed;
    update_t               want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  wch_sample_if pix ();
  wch_result_if upd ();

  always #2 clk = ~clk;

  weighted_color_histogram u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sample    (pix),
    .result    (upd)
  );

  // histogram model state
  logic [DATA_W-1:0]       range_lo [NUM_CH];
  logic [DATA_W-1:0]       range_hi [NUM_CH];
  logic signed [BIN_W-1:0] hist_model [DEPTH];
  logic signed [TOT_W-1:0] total_model;
  update_t                 pending_q [$];

  int mismatches = 0;
  int n_checked = 0;
  int n_dropped = 0;
  int n_clipped = 0;
  int n_settings = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  function automatic bit bin_of(input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] lo,
                                input logic [DATA_W-1:0] hi, input int nbins,
                                input bit pre, output int unsigned idx);
    int unsigned span;
    int unsigned q;
    idx = 0;
    if (pre) begin
      if (v >= nbins) return 1'b0;
      idx = v;
      return 1'b1;
    end
    if (hi <= lo) return 1'b0;
    if (v < lo || v > hi) return 1'b0;
    // top of the range lands in the last bin
    if (v == hi) begin
      idx = nbins - 1;
      return 1'b1;
    end
    span = hi - lo;
    q = v - lo;
    q = q * int'(nbins) / span;
    idx = (q >= nbins) ? nbins - 1 : q;
    return 1'b1;
  endfunction

  function automatic update_t predict_bin(input pixel_t px);
    update_t           r;
    int unsigned       ia;
    int unsigned       ib;
    int unsigned       ic;
    bit                ok;
    logic [ADDR_W-1:0] addr;
    longint            wv;
    longint            s;
    ok = bin_of(px.a, range_lo[0], range_hi[0], BINS_A, px.prebinned, ia);
    ok = bin_of(px.b, range_lo[1], range_hi[1], BINS_B, px.prebinned, ib) && ok;
    ok = bin_of(px.c, range_lo[2], range_hi[2], BINS_C, px.prebinned, ic) && ok;
    if (!ok) begin
      r.idx = '0;
      r.val = '0;
      r.tot = total_model;
      r.dropped = 1'b1;
      n_dropped++;
      return r;
    end
    addr = ADDR_W'((ic * BINS_B + ib) * BINS_A + ia);
    wv = longint'(px.w);
    if (px.func == OP_SUB) wv = -wv;
    s = longint'(hist_model[addr]) + wv;
    if (s > BIN_HI) begin
      s = BIN_HI;
      n_clipped++;
    end else if (s < BIN_LO) begin
      s = BIN_LO;
      n_clipped++;
    end
    hist_model[addr] = BIN_W'(s);
    // total takes the full weight even when the bin clipped
    s = longint'(total_model) + wv;
    if (s > TOT_HI) s = TOT_HI;
    if (s < TOT_LO) s = TOT_LO;
    total_model = TOT_W'(s);
    r.idx = addr;
    r.val = hist_model[addr];
    r.tot = total_model;
    r.dropped = 1'b0;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_chan(input logic [DATA_W-1:0] lo,
                                                  input logic [DATA_W-1:0] hi);
    int k;
    k = $urandom_range(19);
    if (hi <= lo) return DATA_W'($urandom_range(65535));
    if (k == 0) return lo;
    if (k == 1) return hi;
    if (k == 2 && lo > 0) return lo - 1'b1;
    if (k == 3 && hi < 16'hFFFF) return hi + 1'b1;
    return DATA_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [DATA_W-1:0] pick_index(input int nbins);
    int k;
    k = $urandom_range(19);
    if (k == 0) return DATA_W'($urandom_range(65535));
    if (k == 1) return DATA_W'(nbins);
    // crowd a few bins so updates land on the same entry back to back
    if (k < 8) return DATA_W'($urandom_range(1));
    return DATA_W'($urandom_range(nbins - 1));
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     r;
    int     k;
    r = $urandom_range(99);
    k = $urandom_range(9);
    px.func = $urandom_range(1);
    px.w = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : DATA_W'($urandom_range(65535));
    if (r < 35) begin
      px.prebinned = 1'b1;
      px.a = pick_index(BINS_A);
      px.b = pick_index(BINS_B);
      px.c = pick_index(BINS_C);
    end else if (r < 85) begin
      px.prebinned = 1'b0;
      px.a = pick_chan(range_lo[0], range_hi[0]);
      px.b = pick_chan(range_lo[1], range_hi[1]);
      px.c = pick_chan(range_lo[2], range_hi[2]);
    end else begin
      px.prebinned = $urandom_range(1);
      px.a = DATA_W'($urandom_range(65535));
      px.b = DATA_W'($urandom_range(65535));
      px.c = DATA_W'($urandom_range(65535));
    end
    return px;
  endfunction

  function automatic row_t item_row(input logic f, input logic pre,
                                    input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                    input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] w);
    row_t r;
    r.kind = ROW_ITEM;
    r.px = '{f, pre, a, b, c, w};
    r.reg_idx = '0;
    r.reg_val = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t item_row_exp(input logic f, input logic pre,
                                        input logic [DATA_W-1:0] a,
                                        input logic [DATA_W-1:0] b,
                                        input logic [DATA_W-1:0] c,
                                        input logic [DATA_W-1:0] w,
                                        input logic [ADDR_W-1:0] idx, input longint val,
                                        input longint tot, input logic drop);
    row_t r;
    r = item_row(f, pre, a, b, c, w);
    r.typed = 1'b1;
    r.want = '{idx, BIN_W'(val), TOT_W'(tot), drop};
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [DATA_W-1:0] val);
    row_t r;
    r.kind = ROW_CFG;
    r.px = '0;
    r.reg_idx = idx;
    r.reg_val = val;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic push_pixel(input pixel_t px, input bit typed, input update_t want);
    update_t got;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid     <= 1'b1;
    pix.func      <= px.func;
    pix.prebinned <= px.prebinned;
    pix.chan_a    <= px.a;
    pix.chan_b    <= px.b;
    pix.chan_c    <= px.c;
    pix.weight    <= px.w;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    got = predict_bin(px);
    pending_q.push_back(typed ? want : got);
  endtask

  // stop offering items and wait until every result is back
  task automatic drain();
    @(negedge clk);
    pix.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_CHAN_A: range_lo[0] = val;
      REG_MAX_CHAN_A: range_hi[0] = val;
      REG_MIN_CHAN_B: range_lo[1] = val;
      REG_MAX_CHAN_B: range_hi[1] = val;
      REG_MIN_CHAN_C: range_lo[2] = val;
      REG_MAX_CHAN_C: range_hi[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_ranges(input logic [DATA_W-1:0] lo_a, input logic [DATA_W-1:0] hi_a,
                            input logic [DATA_W-1:0] lo_b, input logic [DATA_W-1:0] hi_b,
                            input logic [DATA_W-1:0] lo_c, input logic [DATA_W-1:0] hi_c);
    drain();
    write_reg(REG_MIN_CHAN_A, lo_a);
    write_reg(REG_MAX_CHAN_A, hi_a);
    write_reg(REG_MIN_CHAN_B, lo_b);
    write_reg(REG_MAX_CHAN_B, hi_b);
    write_reg(REG_MIN_CHAN_C, lo_c);
    write_reg(REG_MAX_CHAN_C, hi_c);
    n_settings++;
  endtask

  // result checker
  always @(posedge clk) begin
    update_t got;
    update_t want;
    if (!rst && upd.valid && upd.ready) begin
      got = '{upd.bin_index, upd.bin_value, upd.weight_total, upd.dropped};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result with no item pending: idx %0d val %0d tot %0d drop %0b",
                   got.idx, got.val, got.tot, got.dropped);
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (got.idx !== want.idx || got.val !== want.val || got.tot !== want.tot ||
            got.dropped !== want.dropped) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result %0d: expected idx %0d val %0d tot %0d drop %0b, %s%0d %0d %0d %0b",
                     n_checked, want.idx, want.val, want.tot, want.dropped,
                     "got ", got.idx, got.val, got.tot, got.dropped);
        end
      end
    end
  end

  // receiver side: random stalls plus one long hold-off
  initial begin
    upd.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        upd.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      upd.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (upd.valid && upd.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 stall_cycles, pending_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t        plan [$];
    pixel_t      px;
    logic [15:0] lo [NUM_CH];
    logic [15:0] hi [NUM_CH];

    pix.valid     = 1'b0;
    pix.func      = 1'b0;
    pix.prebinned = 1'b0;
    pix.chan_a    = '0;
    pix.chan_b    = '0;
    pix.chan_c    = '0;
    pix.weight    = '0;
    foreach (hist_model[i]) hist_model[i] = '0;
    total_model = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      range_lo[ch] = 16'h0000;
      range_hi[ch] = 16'hFFFF;
    end

    // directed items, reset ranges first
    plan.push_back(item_row_exp(OP_ADD, 1, 0, 0, 0, 16'h0100, 0, 256, 256, 0));
    plan.push_back(item_row_exp(OP_ADD, 1, 15, 15, 15, 16'hFFFF, 4095, 65535, 65791, 0));
    plan.push_back(item_row_exp(OP_SUB, 1, 15, 15, 15, 16'hFFFF, 4095, 0, 256, 0));
    plan.push_back(item_row_exp(OP_ADD, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                                4095, 1, 257, 0));
    plan.push_back(item_row_exp(OP_ADD, 0, 0, 0, 0, 0, 0, 256, 257, 0));
    plan.push_back(item_row_exp(OP_ADD, 1, 16, 0, 0, 16'hFFFF, 0, 0, 257, 1));
    plan.push_back(item_row_exp(OP_SUB, 1, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0, 257, 1));
    plan.push_back(item_row_exp(OP_SUB, 1, 0, 0, 16'h8000, 16'h00FF, 0, 0, 257, 1));
    plan.push_back(item_row(OP_SUB, 1, 1, 2, 3, 16'h00FF));
    plan.push_back(item_row(OP_ADD, 0, 16'h8000, 16'h1000, 16'hF000, 16'h1234));
    plan.push_back(item_row(OP_ADD, 0, 16'hFFFE, 16'h0FFF, 16'h0001, 16'hFFFF));
    plan.push_back(cfg_row(REG_MIN_CHAN_A, 100));
    plan.push_back(cfg_row(REG_MAX_CHAN_A, 200));
    plan.push_back(item_row(OP_ADD, 0, 99, 0, 0, 16'h0200));
    plan.push_back(item_row(OP_ADD, 0, 201, 0, 0, 16'h0200));
    plan.push_back(item_row(OP_ADD, 0, 100, 5, 5, 16'h0300));
    plan.push_back(item_row(OP_SUB, 0, 200, 5, 5, 16'h0400));
    plan.push_back(item_row(OP_ADD, 0, 199, 5, 5, 16'h8001));
    // equal bounds on b
    plan.push_back(cfg_row(REG_MIN_CHAN_B, 5000));
    plan.push_back(cfg_row(REG_MAX_CHAN_B, 5000));
    plan.push_back(item_row(OP_ADD, 0, 150, 5000, 0, 16'h0100));
    plan.push_back(item_row(OP_ADD, 1, 1, 1, 1, 16'h0100));
    // inverted bounds on c
    plan.push_back(cfg_row(REG_MIN_CHAN_C, 60000));
    plan.push_back(cfg_row(REG_MAX_CHAN_C, 1000));
    plan.push_back(cfg_row(REG_MIN_CHAN_B, 0));
    plan.push_back(cfg_row(REG_MAX_CHAN_B, 16'hFFFF));
    plan.push_back(item_row(OP_ADD, 0, 150, 7, 2000, 16'h0100));
    plan.push_back(item_row(OP_SUB, 1, 2, 7, 9, 16'h7FFF));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        lo[ch] = $urandom_range(60000);
        hi[ch] = lo[ch] + 16'($urandom_range(65535 - lo[ch], 1));
      end
      case (p)
        0: set_ranges(0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF);
        1: set_ranges(0, 1, 16'hFFFE, 16'hFFFF, 1000, 50000);
        2: set_ranges(100, 116, 0, 15, 0, 4095);
        3: set_ranges(300, 200, 7, 7, lo[2], hi[2]);
        4: set_ranges(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
        5: set_ranges(0, 16'hFFFF, 32768, 32769, 16'hFFFF, 16'hFFFF);
        default: set_ranges(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
      endcase
      // make the block back up behind a stalled receiver
      if (p == 1) hold_req = 1'b1;
      repeat (ITEMS_PER_SETTING) push_pixel(random_pixel(), 1'b0, '0);
    end

    // back-to-back full weight into two bins, no idling on either side
    drain();
    quiet = 1'b1;
    px = '{OP_ADD, 1'b1, 16'd3, 16'd3, 16'd3, 16'hFFFF};
    repeat (QUIET_RUN) push_pixel(px, 1'b0, '0);
    px.func = OP_SUB;
    repeat (2) push_pixel(px, 1'b0, '0);
    px = '{OP_SUB, 1'b1, 16'd12, 16'd12, 16'd12, 16'hFFFF};
    repeat (QUIET_RUN) push_pixel(px, 1'b0, '0);
    px.func = OP_ADD;
    repeat (2) push_pixel(px, 1'b0, '0);
    quiet = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results over %0d range settings plus reset ranges", n_checked,
             n_settings);
    $display("%0d dropped items, %0d clipped bin updates, %0d mismatches", n_dropped,
             n_clipped, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
